[hw/rtl/twe_pkg.sv]
// ----------------------------------------------------------------------------
// twe_pkg
// Shared constants, types and helpers for the timing wheel timeout engine.
// ----------------------------------------------------------------------------
package twe_pkg;

   localparam int WHEEL_SLOTS   = 60;
   localparam int TIMER_ENTRIES = 16;

   localparam int REM_W = $clog2(WHEEL_SLOTS + 1);
   localparam int IDX_W = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TIMER_ENTRIES + 1);

   localparam int MODE_W = 2;
   localparam int ID_W   = 4;
   localparam int TMO_W  = 6;

   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REFRESH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CANCEL  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd3;

   typedef struct packed {
      logic [REM_W-1:0] period;
      logic [REM_W-1:0] remain;
   } mem_word_type;

   // timeout mod wheel size, zero meaning a full revolution
   function automatic logic [REM_W-1:0] eff_ticks(input logic [TMO_W-1:0] t);
      logic [REM_W-1:0] r;
      r = '0;
      for (int v = 0; v < (1 << TMO_W); v++) begin
         if (t == TMO_W'(v)) begin
            r = REM_W'(((v % WHEEL_SLOTS) == 0) ? WHEEL_SLOTS : (v % WHEEL_SLOTS));
         end
      end
      return r;
   endfunction

endpackage

[hw/rtl/timing_wheel_timeout_engine.sv]
// ----------------------------------------------------------------------------
// timing_wheel_timeout_engine
// Timer table with add, refresh, cancel and tick; a tick sweeps the entry
// memory and reports every timer that runs out, last one flagged by tlast.
// ----------------------------------------------------------------------------
// add and cancel complete on acceptance; refresh reads the entry, then writes it back in ST_REFR
// tick: one entry per cycle through the timer memory's read and write ports,
//   held while the result word is stalled
// reset: synchronous, clears active and cancel flags and all control state;
//   the timer memory needs no clearing pass
module timing_wheel_timeout_engine
   import twe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // timer_id[3:0], timeout_ticks[9:4]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // expired_id[3:0]
   output logic [0:0]  rsp_tuser,   // callback_runs[0]
   output logic        rsp_tlast    // last_expiry
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_REFR  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [TIMER_ENTRIES-1:0] active_ff, active_in;
   logic [TIMER_ENTRIES-1:0] cancel_ff, cancel_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [IDX_W-1:0]         proc_ff, proc_in;
   logic                     proc_vld_ff, proc_vld_in;
   logic                     pend_vld_ff, pend_vld_in;
   logic [ID_W-1:0]          pend_id_ff, pend_id_in;
   logic                     pend_cb_ff, pend_cb_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   logic [ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic                     rsp_cb_ff, rsp_cb_in;
   logic                     rsp_last_ff, rsp_last_in;

   mem_word_type             timer_mem [TIMER_ENTRIES];
   mem_word_type             rd_data_ff;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   mem_word_type             wr_data;

   logic                     req_acc;
   logic [MODE_W-1:0]        req_mode;
   logic [ID_W-1:0]          req_id;
   logic [TMO_W-1:0]         req_tmo;
   logic                     id_ok;
   logic [IDX_W-1:0]         id_idx;
   logic [REM_W-1:0]         add_ticks;
   logic                     expire;
   logic                     rsp_free;
   logic                     advance;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_mode   = req_tuser;
   assign req_id     = req_tdata[ID_W-1:0];
   assign req_tmo    = req_tdata[ID_W+TMO_W-1:ID_W];
   assign id_ok      = int'(req_id) < TIMER_ENTRIES;
   assign id_idx     = IDX_W'(req_id);
   assign add_ticks  = eff_ticks(req_tmo);

   assign expire   = proc_vld_ff && active_ff[proc_ff] && (rd_data_ff.remain == REM_W'(1));
   assign rsp_free = !rsp_vld_ff || rsp_tready;
   assign advance  = !(expire && pend_vld_ff && !rsp_free);

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      cancel_in   = cancel_ff;
      scan_in     = scan_ff;
      proc_in     = proc_ff;
      proc_vld_in = proc_vld_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      pend_cb_in  = pend_cb_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_id_in   = rsp_id_ff;
      rsp_cb_in   = rsp_cb_ff;
      rsp_last_in = rsp_last_ff;
      rd_en       = 1'b0;
      rd_addr     = scan_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = proc_ff;
      wr_data     = '{period: rd_data_ff.period, remain: rd_data_ff.remain - REM_W'(1)};

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_mode)
                  MODE_ADD: begin
                     if (id_ok) begin
                        active_in[id_idx] = 1'b1;
                        cancel_in[id_idx] = 1'b0;
                        wr_en             = 1'b1;
                        wr_addr           = id_idx;
                        wr_data           = '{period: add_ticks, remain: add_ticks};
                     end
                  end
                  MODE_REFRESH: begin
                     if (id_ok && active_ff[id_idx]) begin
                        rd_en    = 1'b1;
                        rd_addr  = id_idx;
                        proc_in  = id_idx;
                        state_in = ST_REFR;
                     end
                  end
                  MODE_CANCEL: begin
                     if (id_ok && active_ff[id_idx]) begin
                        cancel_in[id_idx] = 1'b1;
                     end
                  end
                  MODE_TICK: begin
                     scan_in     = '0;
                     proc_vld_in = 1'b0;
                     state_in    = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REFR: begin
            wr_en    = 1'b1;
            wr_addr  = proc_ff;
            wr_data  = '{period: rd_data_ff.period, remain: rd_data_ff.period};
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (advance) begin
               if (proc_vld_ff && active_ff[proc_ff]) begin
                  wr_en = 1'b1;
               end
               if (expire) begin
                  active_in[proc_ff] = 1'b0;
                  cancel_in[proc_ff] = 1'b0;
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_id_in   = pend_id_ff;
                     rsp_cb_in   = pend_cb_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_id_in  = ID_W'(proc_ff);
                  pend_cb_in  = !cancel_ff[proc_ff];
               end
               if (int'(scan_ff) < TIMER_ENTRIES) begin
                  rd_en       = 1'b1;
                  proc_in     = scan_ff[IDX_W-1:0];
                  proc_vld_in = 1'b1;
                  scan_in     = scan_ff + CNT_W'(1);
               end else begin
                  proc_vld_in = 1'b0;
                  state_in    = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_id_in   = pend_id_ff;
               rsp_cb_in   = pend_cb_ff;
               rsp_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         active_ff   <= '0;
         cancel_ff   <= '0;
         scan_ff     <= '0;
         proc_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         cancel_ff   <= cancel_in;
         scan_ff     <= scan_in;
         proc_vld_ff <= proc_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff     <= proc_in;
      pend_id_ff  <= pend_id_in;
      pend_cb_ff  <= pend_cb_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_cb_ff   <= rsp_cb_in;
      rsp_last_ff <= rsp_last_in;
   end

   // timer memory, one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         timer_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= timer_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_id_ff};
   assign rsp_tuser  = rsp_cb_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hw/rtl/twe_checker.sv]
// ----------------------------------------------------------------------------
// twe_checker
// Port-level checks for the timing wheel timeout engine, bound to the top.
// ----------------------------------------------------------------------------
module twe_checker
   import twe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled word stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // nothing out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word after reset");

   // a tick holds off new words while it sweeps
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_TICK) |=> !req_tready)
      else $error("input taken during sweep");

   // an unfinished run keeps the input closed
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open inside a run");

endmodule

bind timing_wheel_timeout_engine twe_checker u_twe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
